>>> rtl/hhe_pkg.sv
// Shared types, constants and helpers for the HTTP host extractor.
package hhe_pkg;

    localparam int unsigned ETH_HEADER_BYTES = 14;
    localparam int unsigned MAX_NAME_LEN     = 255;
    localparam int unsigned MIN_HEADER_BYTES = 20;
    localparam int unsigned KEY_LEN          = 6;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_KEY_H  = 8'h48;

    // IPv4 header byte offsets.
    localparam logic [15:0] IP_OFS_VER_IHL   = 16'd0;
    localparam logic [15:0] IP_OFS_LEN_HI    = 16'd2;
    localparam logic [15:0] IP_OFS_LEN_LO    = 16'd3;
    localparam logic [15:0] IP_OFS_SRC_FIRST = 16'd12;
    localparam logic [15:0] IP_OFS_SRC_LAST  = 16'd15;
    localparam logic [15:0] IP_OFS_DST_FIRST = 16'd16;
    localparam logic [15:0] IP_OFS_DST_LAST  = 16'd19;
    // TCP header byte offset of the data offset field.
    localparam logic [15:0] TCP_OFS_DATA_OFS = 16'd12;

    typedef enum logic [1:0] {
        KIND_DOMAIN_BYTE = 2'd0,
        KIND_DOMAIN_DONE = 2'd1,
        KIND_BAD_IP_HDR  = 2'd2,
        KIND_BAD_TCP_HDR = 2'd3
    } t_result_kind;

    typedef enum logic [5:0] {
        PH_ETH     = 6'b000001,
        PH_IP      = 6'b000010,
        PH_TCP     = 6'b000100,
        PH_SEARCH  = 6'b001000,
        PH_CAPTURE = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic         valid;
        t_result_kind kind;
        logic [7:0]   domain_char;
        logic [31:0]  source_address;
        logic [31:0]  dest_address;
        logic [7:0]   name_length;
        logic         name_truncated;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] byte_position;
    } t_parse_status;

    // Byte of the "Host: " key at a given match index.
    function automatic logic [7:0] key_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h48;
            3'd1:    r = 8'h6F;
            3'd2:    r = 8'h73;
            3'd3:    r = 8'h74;
            3'd4:    r = 8'h3A;
            3'd5:    r = 8'h20;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/hhe_parser.sv
// Per-frame parse state and the next-state logic for one frame byte.
module hhe_parser import hhe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    output t_result       o_result,
    output t_parse_status o_status
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [5:0]  r_ip_bytes, n_ip_bytes;
    logic [5:0]  r_tcp_bytes, n_tcp_bytes;
    logic [15:0] r_total_len, n_total_len;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [2:0]  r_key_cnt, n_key_cnt;
    logic [7:0]  r_cap_len, n_cap_len;
    logic        r_cr_seen, n_cr_seen;
    logic        r_cut, n_cut;

    logic [15:0] ofs;
    logic [16:0] ofs_plus1;
    logic [15:0] tcp_ofs;
    logic [16:0] tcp_ofs_plus1;
    logic [16:0] pos_plus1;
    t_result     res;

    always_comb begin
        ofs           = (r_pos >= 16'(ETH_HEADER_BYTES)) ? r_pos - 16'(ETH_HEADER_BYTES) : '0;
        ofs_plus1     = {1'b0, ofs} + 17'd1;
        pos_plus1     = {1'b0, r_pos} + 17'd1;
        tcp_ofs       = ofs - {10'b0, r_ip_bytes};
        tcp_ofs_plus1 = {1'b0, tcp_ofs} + 17'd1;

        n_phase     = r_phase;
        n_pos       = r_pos;
        n_ip_bytes  = r_ip_bytes;
        n_tcp_bytes = r_tcp_bytes;
        n_total_len = r_total_len;
        n_src       = r_src;
        n_dst       = r_dst;
        n_key_cnt   = r_key_cnt;
        n_cap_len   = r_cap_len;
        n_cr_seen   = r_cr_seen;
        n_cut       = r_cut;
        res         = '0;

        case (r_phase)
            PH_ETH: begin
                if (pos_plus1 >= 17'(ETH_HEADER_BYTES)) begin
                    n_phase = PH_IP;
                end
            end
            PH_IP: begin
                if (ofs == IP_OFS_VER_IHL) begin
                    n_ip_bytes = {i_byte[3:0], 2'b00};
                end else if (ofs == IP_OFS_LEN_HI) begin
                    n_total_len = {i_byte, 8'h00};
                end else if (ofs == IP_OFS_LEN_LO) begin
                    n_total_len = {r_total_len[15:8], i_byte};
                end else if (ofs >= IP_OFS_SRC_FIRST && ofs <= IP_OFS_SRC_LAST) begin
                    n_src = {r_src[23:0], i_byte};
                end else if (ofs >= IP_OFS_DST_FIRST && ofs <= IP_OFS_DST_LAST) begin
                    n_dst = {r_dst[23:0], i_byte};
                end
                if (ofs == IP_OFS_VER_IHL && n_ip_bytes < 6'(MIN_HEADER_BYTES)) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD_IP_HDR;
                    n_phase   = PH_DONE;
                end else if (ofs_plus1 >= {11'b0, n_ip_bytes}) begin
                    n_phase = PH_TCP;
                end
            end
            PH_TCP: begin
                if (tcp_ofs == TCP_OFS_DATA_OFS) begin
                    n_tcp_bytes = {i_byte[7:4], 2'b00};
                end
                if (tcp_ofs == TCP_OFS_DATA_OFS && n_tcp_bytes < 6'(MIN_HEADER_BYTES)) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD_TCP_HDR;
                    n_phase   = PH_DONE;
                end else if (tcp_ofs_plus1 == {11'b0, n_tcp_bytes}) begin
                    n_phase = PH_SEARCH;
                end
            end
            PH_SEARCH: begin
                if (ofs >= r_total_len) begin
                    n_phase = PH_DONE;
                end else begin
                    if (r_key_cnt < 3'(KEY_LEN) && i_byte == key_byte(r_key_cnt)) begin
                        n_key_cnt = r_key_cnt + 3'd1;
                    end else begin
                        n_key_cnt = (i_byte == CHAR_KEY_H) ? 3'd1 : 3'd0;
                    end
                    if (n_key_cnt >= 3'(KEY_LEN)) begin
                        n_phase   = PH_CAPTURE;
                        n_cap_len = '0;
                        n_cr_seen = 1'b0;
                        n_cut     = 1'b0;
                    end
                end
            end
            PH_CAPTURE: begin
                if (ofs >= r_total_len) begin
                    n_phase = PH_DONE;
                end else if (r_cr_seen && i_byte == CHAR_LF) begin
                    n_cr_seen            = 1'b0;
                    res.valid            = 1'b1;
                    res.kind             = KIND_DOMAIN_DONE;
                    res.source_address   = r_src;
                    res.dest_address     = r_dst;
                    res.name_length      = r_cap_len;
                    res.name_truncated   = r_cut;
                    n_phase              = PH_DONE;
                end else if (i_byte == CHAR_CR) begin
                    n_cr_seen = 1'b1;
                end else begin
                    n_cr_seen = 1'b0;
                    if (r_cap_len < 8'(MAX_NAME_LEN)) begin
                        res.valid       = 1'b1;
                        res.kind        = KIND_DOMAIN_BYTE;
                        res.domain_char = i_byte;
                        n_cap_len       = r_cap_len + 8'd1;
                    end else begin
                        n_cut = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end

        // The last byte of a frame is handled first, then everything starts over.
        if (i_end) begin
            n_phase     = PH_ETH;
            n_pos       = '0;
            n_ip_bytes  = '0;
            n_tcp_bytes = '0;
            n_total_len = '0;
            n_src       = '0;
            n_dst       = '0;
            n_key_cnt   = '0;
            n_cap_len   = '0;
            n_cr_seen   = 1'b0;
            n_cut       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ETH;
            r_pos       <= '0;
            r_ip_bytes  <= '0;
            r_tcp_bytes <= '0;
            r_total_len <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_key_cnt   <= '0;
            r_cap_len   <= '0;
            r_cr_seen   <= 1'b0;
            r_cut       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_ip_bytes  <= n_ip_bytes;
            r_tcp_bytes <= n_tcp_bytes;
            r_total_len <= n_total_len;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_key_cnt   <= n_key_cnt;
            r_cap_len   <= n_cap_len;
            r_cr_seen   <= n_cr_seen;
            r_cut       <= n_cut;
        end
    end

    assign o_result = res;
    assign o_status = '{phase: r_phase, byte_position: r_pos};

endmodule

>>> rtl/http_host_extractor_core.sv
// Top level of the HTTP host extractor: input register, parser and result register.
//
//   Channel   Handshake                  Beat payload
//   --------  -------------------------  ---------------------------------------------
//   in        i_in_valid / o_in_ready    i_frame_byte, i_frame_end
//   out       o_out_valid / i_out_ready  o_result_kind, o_domain_char, o_source_address,
//                                        o_dest_address, o_name_length, o_name_truncated
//
// One frame byte is accepted per cycle while the result side keeps up. A byte accepted
// into the input register is parsed out of it when the parser consumes it, which also
// loads its result, if any, into the result register, from which the result beat is taken.
// A synchronous active-low reset clears both valid bits and all parse state, and holds
// the input ready low while it is asserted.
// When the result register is full and not taken, the input register holds its byte
// and the input side backs up; otherwise a new byte can enter every cycle.
module http_host_extractor_core import hhe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_domain_char,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [7:0]  o_name_length,
    output logic        o_name_truncated
);

    // Input register holding the next byte to parse.
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_end;

    // Result register.
    logic          r_out_valid;
    t_result       r_out;

    logic          consume;
    t_result       parse_res;
    t_parse_status parse_status;

    // The parser consumes the held byte whenever the result register has room
    // for whatever that byte produces, or is being drained this cycle.
    // Nothing is taken in while reset is held.
    assign consume    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_frame_byte;
            r_in_end  <= i_frame_end;
        end
    end

    hhe_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (consume),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_result (parse_res),
        .o_status (parse_status)
    );

    // A consumed byte either loads a new result or leaves the register empty;
    // a byte that produces nothing only proceeds once the old result is gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume) begin
            r_out_valid <= parse_res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && parse_res.valid) begin
            r_out <= parse_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_domain_char    = r_out.domain_char;
    assign o_source_address = r_out.source_address;
    assign o_dest_address   = r_out.dest_address;
    assign o_name_length    = r_out.name_length;
    assign o_name_truncated = r_out.name_truncated;

    // A held byte that is not consumed stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_end)))
        else $error("input register lost or changed a held byte");

    // The last byte of a frame returns the parser to the start of a new frame.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_end) |=>
            (parse_status.phase == PH_ETH && parse_status.byte_position == 16'd0))
        else $error("parser did not restart after end of frame");

    // Once a frame is finished, nothing more is reported for it.
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && parse_status.phase == PH_DONE) |-> !parse_res.valid)
        else $error("result produced after frame was finished");

    // Only domain byte beats carry a character.
    a_char_only_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != KIND_DOMAIN_BYTE) |-> (o_domain_char == 8'd0))
        else $error("domain character set on a non-byte result");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the HTTP host extractor core.
`timescale 1ns / 100ps

module tb;
    import hhe_pkg::*;

    // A run with no beat on either side for this many cycles is hung. The longest
    // legal silence is the deliberate receiver hold-off below.
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    // Each byte passes the core's input and result registers, so a short tail catches late records.
    localparam int DRAIN_CYCLES  = 8;
    // Byte budget of the whole run, directed frames included.
    localparam int TOTAL_BYTES   = 1950;
    localparam int NUM_PHASES    = 4;
    localparam int REPORT_LIMIT  = 10;
    localparam string CRLF       = "\015\012";

    // One output beat, with the kind kept as a plain vector so that an X from the
    // core still compares as a mismatch.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  domain_char;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  len;
        logic        cut;
    } t_host_record;

    // The scoreboard runs its own copy of the frame parser. Every accepted frame
    // byte advances that copy and may queue one record; every record the core
    // delivers is matched against the oldest queued one.
    class host_scoreboard;
        t_host_record pending[$];
        int unsigned  errors;
        int unsigned  pos;
        int unsigned  ip_hdr;
        int unsigned  tcp_hdr;
        int unsigned  total_len;
        int unsigned  key_idx;
        int unsigned  name_len;
        t_phase       phase;
        logic [31:0]  src;
        logic [31:0]  dst;
        bit           cr_seen;
        bit           cut;
        string        host_key;

        function new();
            errors   = 0;
            host_key = "Host: ";
            clear_frame();
        endfunction

        function void clear_frame();
            pos       = 0;
            phase     = PH_ETH;
            ip_hdr    = 0;
            tcp_hdr   = 0;
            total_len = 0;
            src       = '0;
            dst       = '0;
            key_idx   = 0;
            name_len  = 0;
            cr_seen   = 0;
            cut       = 0;
        endfunction

        function void add_record(logic [1:0] kind, logic [7:0] ch, logic [31:0] s,
                                 logic [31:0] d, logic [7:0] len, logic c);
            pending.push_back('{kind, ch, s, d, len, c});
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned ofs;
            int unsigned t;
            ofs = (pos >= ETH_HEADER_BYTES) ? pos - ETH_HEADER_BYTES : 0;
            case (phase)
                PH_ETH: begin
                    if (pos + 1 >= ETH_HEADER_BYTES) phase = PH_IP;
                end
                PH_IP: begin
                    if (ofs == 0) ip_hdr = 4 * b[3:0];
                    if (ofs == 0 && ip_hdr < MIN_HEADER_BYTES) begin
                        add_record(KIND_BAD_IP_HDR, '0, '0, '0, '0, 1'b0);
                        phase = PH_DONE;
                    end else begin
                        if (ofs == 2) total_len = {16'h0000, b, 8'h00};
                        else if (ofs == 3) total_len[7:0] = b;
                        else if (ofs >= 12 && ofs <= 15) src = {src[23:0], b};
                        else if (ofs >= 16 && ofs <= 19) dst = {dst[23:0], b};
                        if (ofs + 1 >= ip_hdr) phase = PH_TCP;
                    end
                end
                PH_TCP: begin
                    t = ofs - ip_hdr;
                    if (t == 12) tcp_hdr = 4 * b[7:4];
                    if (t == 12 && tcp_hdr < MIN_HEADER_BYTES) begin
                        add_record(KIND_BAD_TCP_HDR, '0, '0, '0, '0, 1'b0);
                        phase = PH_DONE;
                    end else if (t + 1 == tcp_hdr) begin
                        phase = PH_SEARCH;
                    end
                end
                PH_SEARCH: begin
                    if (ofs >= total_len) begin
                        phase = PH_DONE;
                    end else begin
                        if (key_idx < KEY_LEN && b == host_key[key_idx]) key_idx++;
                        else key_idx = (b == host_key[0]) ? 1 : 0;
                        if (key_idx >= KEY_LEN) begin
                            phase    = PH_CAPTURE;
                            name_len = 0;
                            cr_seen  = 0;
                            cut      = 0;
                        end
                    end
                end
                PH_CAPTURE: begin
                    if (ofs >= total_len) begin
                        phase = PH_DONE;
                    end else if (cr_seen && b == CHAR_LF) begin
                        add_record(KIND_DOMAIN_DONE, '0, src, dst, name_len[7:0], cut);
                        phase = PH_DONE;
                    end else begin
                        // A CR waits for its LF; a CR not followed by LF just vanishes.
                        cr_seen = (b == CHAR_CR);
                        if (!cr_seen) begin
                            if (name_len < MAX_NAME_LEN) begin
                                add_record(KIND_DOMAIN_BYTE, b, '0, '0, '0, 1'b0);
                                name_len++;
                            end else begin
                                cut = 1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (pos < 32'h0000_FFFF) pos++;
            if (last) clear_frame();
        endfunction

        function void check_record(t_host_record got);
            t_host_record want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: record with nothing pending: kind %0d char %h len %0d",
                             $time, got.kind, got.domain_char, got.len);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"%0t: record mismatch: kind %0d/%0d char %h/%h ",
                                  "src %h/%h dst %h/%h len %0d/%0d cut %b/%b (exp/act)"},
                                 $time, want.kind, got.kind, want.domain_char,
                                 got.domain_char, want.src, got.src, want.dst, got.dst,
                                 want.len, got.len, want.cut, got.cut);
                end
            end
        endfunction

        function int unsigned failures();
            return errors + pending.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  frame_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  domain_char;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  name_length;
    logic        name_truncated;

    host_scoreboard sb;
    logic [7:0]     frame_q[$];
    int             bytes_sent = 0;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             quiet_cycles = 0;
    bit             hold_request = 1'b0;

    http_host_extractor_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_frame_byte     (frame_byte),
        .i_frame_end      (frame_end),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (result_kind),
        .o_domain_char    (domain_char),
        .o_source_address (source_address),
        .o_dest_address   (dest_address),
        .o_name_length    (name_length),
        .o_name_truncated (name_truncated)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Both handshakes are sampled here, once per edge, before any driver update of
    // that edge takes effect. Input beats feed the parser copy, output beats are
    // checked, and the watchdog counts edges with neither.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.take_byte(frame_byte, frame_end);
        if (rst_n && out_valid && out_ready)
            sb.check_record({result_kind, domain_char, source_address, dest_address,
                             name_length, name_truncated});
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver. Normally it stalls at random at the current rate; on request it
    // holds off for a long fixed stretch so that the core backs up into its input.
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offers one beat, with random idle cycles in front of it, and returns at the
    // edge that accepts it. Valid stays up if the next beat follows at once.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        frame_end  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Sender pause: valid drops and nothing is offered until every queued record
    // has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Starts a frame with a random Ethernet header, an IPv4 header of the given
    // IHL and a TCP header of the given data offset. A header field under the
    // minimum still gets 20 bytes on the wire.
    task automatic begin_frame(input logic [3:0] ihl, input logic [3:0] doff,
                               input logic [31:0] src, input logic [31:0] dst);
        int unsigned ip_len;
        int unsigned tcp_len;
        logic [7:0]  b;
        ip_len  = (4 * ihl < MIN_HEADER_BYTES) ? MIN_HEADER_BYTES : 4 * ihl;
        tcp_len = (4 * doff < MIN_HEADER_BYTES) ? MIN_HEADER_BYTES : 4 * doff;
        frame_q.delete();
        repeat (ETH_HEADER_BYTES) frame_q.push_back(8'($urandom));
        for (int i = 0; i < ip_len; i++) begin
            b = 8'($urandom);
            if (i == 0) b[3:0] = ihl;
            else if (i >= 12 && i < 16) b = src[8 * (15 - i) +: 8];
            else if (i >= 16 && i < 20) b = dst[8 * (19 - i) +: 8];
            frame_q.push_back(b);
        end
        for (int i = 0; i < tcp_len; i++) begin
            b = 8'($urandom);
            if (i == 12) b[7:4] = doff;
            frame_q.push_back(b);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    // Appends n printable domain bytes, now and then preceded by a bare CR.
    task automatic add_domain(input int n);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) frame_q.push_back(CHAR_CR);
            frame_q.push_back(8'($urandom_range(33, 126)));
        end
    endtask

    function automatic logic [15:0] ip_bytes();
        return 16'(frame_q.size() - ETH_HEADER_BYTES);
    endfunction

    task automatic set_total_length(input logic [15:0] n);
        if (frame_q.size() > ETH_HEADER_BYTES + 3) begin
            frame_q[ETH_HEADER_BYTES + 2] = n[15:8];
            frame_q[ETH_HEADER_BYTES + 3] = n[7:0];
        end
    endtask

    initial begin : stimulus
        int         sel;
        int         mode;
        int         keep;
        int         target;
        logic [3:0] ihl;
        logic [3:0] doff;
        logic [15:0] total;

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames, sent back to back with the receiver always ready.

        // Shortest domain, all-ones source and all-zeros destination.
        begin_frame(4'd5, 4'd5, 32'hFFFF_FFFF, 32'h0000_0000);
        add_text({"Host: a", CRLF});
        set_total_length(ip_bytes());
        send_frame();

        // Largest headers. Request line first, then near-misses of the key
        // ("Hos " and a doubled H), a bare CR inside the domain, CR CR LF at the
        // end, and a second Host line that must be ignored after completion.
        begin_frame(4'd15, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF);
        add_text({"GET / HTTP/1.1", CRLF, "Hos HHost: ab\015cd\015", CRLF});
        add_text({"Host: zz", CRLF});
        set_total_length(ip_bytes());
        send_frame();

        // Key without its space, then the real key and an empty domain.
        begin_frame(4'd5, 4'd6, $urandom, $urandom);
        add_text({"Host:xHost: ", CRLF});
        set_total_length(ip_bytes());
        send_frame();

        // IP header length of zero and of 16 bytes.
        begin_frame(4'd0, 4'd5, $urandom, $urandom);
        send_frame();
        begin_frame(4'd4, 4'd5, $urandom, $urandom);
        send_frame();

        // TCP data offset of zero and of 16 bytes.
        begin_frame(4'd5, 4'd0, $urandom, $urandom);
        set_total_length(ip_bytes());
        send_frame();
        begin_frame(4'd7, 4'd4, $urandom, $urandom);
        set_total_length(ip_bytes());
        send_frame();

        // Domain of exactly the maximum length, then one that is cut.
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text("Host: ");
        add_domain(MAX_NAME_LEN);
        add_text(CRLF);
        set_total_length(ip_bytes());
        send_frame();
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text("Host: ");
        add_domain(MAX_NAME_LEN + 15);
        add_text(CRLF);
        set_total_length(ip_bytes());
        send_frame();

        // IP total length ends the search before the key is complete.
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text({"xxxxHost: abc", CRLF});
        set_total_length(ip_bytes() - 16'd11);
        send_frame();

        // IP total length ends the capture after two domain bytes.
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text({"Host: abcdef", CRLF});
        set_total_length(ip_bytes() - 16'd6);
        send_frame();

        // Zero total length: the payload is out of bounds from its first byte.
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text({"Host: q", CRLF});
        set_total_length(16'd0);
        send_frame();

        // Ethernet padding past the IP end completes the key only outside it.
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text("Hos");
        set_total_length(ip_bytes());
        add_text({"t: xyz", CRLF});
        send_frame();

        // Frames that end early: one byte, inside the IP header, mid-domain.
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        while (frame_q.size() > ETH_HEADER_BYTES + 6) void'(frame_q.pop_back());
        send_frame();
        begin_frame(4'd5, 4'd5, $urandom, $urandom);
        add_text({"Host: abcdefgh", CRLF});
        set_total_length(ip_bytes());
        while (frame_q.size() > ETH_HEADER_BYTES + 48) void'(frame_q.pop_back());
        send_frame();

        // Random frames in four phases of handshake pressure. Each phase starts
        // from a drained core, gets an even share of what is left of the byte
        // budget, and sends at least one frame.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase

            // Long receiver hold-off while a long domain keeps arriving, so the
            // result register fills and the input side has to stall.
            if (ph == 0) begin
                hold_request = 1'b1;
                begin_frame(4'd5, 4'd5, $urandom, $urandom);
                add_text("Host: ");
                add_domain(60);
                add_text(CRLF);
                set_total_length(ip_bytes());
                send_frame();
            end

            target = bytes_sent + (TOTAL_BYTES - bytes_sent) / (NUM_PHASES - ph);
            do begin
                sel  = $urandom_range(0, 99);
                ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
                doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
                if (sel < 8) ihl = 4'($urandom_range(0, 4));
                else if (sel < 15) doff = 4'($urandom_range(0, 4));

                if (sel >= 95) begin
                    // Pure line noise as a frame.
                    frame_q.delete();
                    add_noise($urandom_range(1, 60));
                end else begin
                    begin_frame(ihl, doff, $urandom, $urandom);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: add_noise($urandom_range(1, 12));
                        2: add_text("Hos");
                        default: add_text("HHost:");
                    endcase
                    add_text("Host: ");
                    if ($urandom_range(0, 59) == 0) add_domain($urandom_range(250, 300));
                    else add_domain($urandom_range(0, 24));
                    add_text(CRLF);
                    add_noise($urandom_range(0, 6));

                    // Mostly an exact total length; sometimes one that cuts the
                    // payload, an arbitrary one, an early frame end, or padding.
                    total = ip_bytes();
                    mode  = $urandom_range(0, 9);
                    if (mode == 0) total = 16'($urandom_range(0, total));
                    else if (mode == 1) total = 16'($urandom);
                    set_total_length(total);
                    if (mode == 2) begin
                        keep = $urandom_range(1, frame_q.size());
                        while (frame_q.size() > keep) void'(frame_q.pop_back());
                    end else if (mode == 3) begin
                        add_noise($urandom_range(1, 20));
                    end
                end
                send_frame();
            end while (bytes_sent < target);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> http_host_extractor_core.f
rtl/hhe_pkg.sv
rtl/hhe_parser.sv
rtl/http_host_extractor_core.sv
tb/tb.sv
